/* hw/rtl/bitmap_glyph_text_renderer_core_macros.svh */
// ----------------------------------------------------------------------------
// Bitmap glyph text renderer - assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_TEXT_RENDERER_CORE_MACROS_SVH
`define BITMAP_GLYPH_TEXT_RENDERER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BGTR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgtr check failed");

// Next-cycle implication, checked outside reset.
`define BGTR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgtr check failed");

// Condition that must hold in the cycle after reset is applied.
`define BGTR_ASSERT_AFTER_RESET(name, clk, rst_n, cons) \
    name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("bgtr reset check failed");

`endif

/* hw/rtl/bgtr_pkg.sv */
// ----------------------------------------------------------------------------
// bgtr_pkg
// Types and constants shared by the glyph renderer front, queue and back end.
// ----------------------------------------------------------------------------
package bgtr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COLS_W     = 9;
    localparam int ROWS_W     = 9;
    localparam int HEIGHT_W   = 6;
    localparam int CODE_W     = 8;
    localparam int OFFS_W     = 6;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 32;
    localparam int PX_W       = 12;
    localparam int PY_W       = 13;
    localparam int BITS_W     = 10;
    localparam int ROWADDR_W  = 14;  // glyph row address, covers 256 glyphs of up to 64 rows
    localparam int ROWIDX_W   = 6;   // glyph row index within a character
    localparam int CMP_W      = 11;  // common width for cursor and limit compares

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd2;

    localparam logic KIND_FONT  = 1'b0;
    localparam logic KIND_PRINT = 1'b1;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    // One unit of work for the back end: a font byte write or a glyph to draw.
    typedef struct packed {
        logic                 is_print;
        logic [ROWADDR_W-1:0] row_addr;
        logic                 bank;
        logic [BYTE_W-1:0]    font_byte;
        logic [ROWIDX_W-1:0]  last_row;
        logic [PX_W-1:0]      pixel_x;
        logic [PY_W-1:0]      pixel_y0;
        logic                 off_screen;
        logic [COLOR_W-1:0]   fg_color;
        logic [COLOR_W-1:0]   bg_color;
    } bgtr_entry_t;

    // Handshake between queue and back end.
    typedef struct packed {
        logic        valid;
        bgtr_entry_t entry;
    } bgtr_head_t;

endpackage

/* hw/rtl/bgtr_front.sv */
// ----------------------------------------------------------------------------
// bgtr_front
// Accepts items, holds configuration and the text cursor, and turns each
// item into a back-end work entry. Newlines and out-of-range font writes
// only touch the cursor or are dropped.
// ----------------------------------------------------------------------------
module bgtr_front #(
    parameter int MAX_COLS         = 256,
    parameter int MAX_ROWS         = 256,
    parameter int MAX_GLYPH_HEIGHT = 32,
    parameter int GLYPH_WIDTH      = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bgtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgtr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [bgtr_pkg::CODE_W-1:0]       s_char_code,
    input  logic [bgtr_pkg::OFFS_W-1:0]       s_font_offset,
    input  logic [bgtr_pkg::BYTE_W-1:0]       s_font_byte,
    input  logic [bgtr_pkg::COLOR_W-1:0]      s_fg_color,
    input  logic [bgtr_pkg::COLOR_W-1:0]      s_bg_color,
    output logic                              push_valid,
    output bgtr_pkg::bgtr_entry_t             push_entry,
    input  logic                              push_ready
);
    import bgtr_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS + 1);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [CMP_W-1:0] COLS_HI   = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] ROWS_HI   = CMP_W'(MAX_ROWS);
    localparam logic [CMP_W-1:0] HEIGHT_HI = CMP_W'(MAX_GLYPH_HEIGHT);
    localparam logic [CMP_W-1:0] GLYPH_BYTES = CMP_W'(2 * MAX_GLYPH_HEIGHT);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MAX_ROWS - 1);

    function automatic logic [CMP_W-1:0] clamp_limit(input logic [CMP_W-1:0] v,
                                                     input logic [CMP_W-1:0] hi);
        logic [CMP_W-1:0] r;
        if (v == '0) begin
            r = CMP_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [COLS_W-1:0]   num_cols_reg;
    logic [ROWS_W-1:0]   num_rows_reg;
    logic [HEIGHT_W-1:0] glyph_height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic [CMP_W-1:0] cols_eff, rows_eff, height_eff;
    logic             accept, is_newline, wrap, font_ok;
    logic [ROW_W-1:0] row_inc, row_eff;
    logic [COL_W-1:0] col_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg     <= COLS_W'(80);
            num_rows_reg     <= ROWS_W'(25);
            glyph_height_reg <= HEIGHT_W'(20);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_NUM_COLS:     num_cols_reg     <= cfg_data[COLS_W-1:0];
                REG_NUM_ROWS:     num_rows_reg     <= cfg_data[ROWS_W-1:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cols_eff   = clamp_limit(CMP_W'(num_cols_reg), COLS_HI);
    assign rows_eff   = clamp_limit(CMP_W'(num_rows_reg), ROWS_HI);
    assign height_eff = clamp_limit(CMP_W'(glyph_height_reg), HEIGHT_HI);

    assign s_ready    = push_ready;
    assign accept     = s_valid && push_ready;
    assign is_newline = (s_char_code == NEWLINE_CODE);

    // Row saturates at the last row; the screen never scrolls.
    assign row_inc = (row_reg == ROW_LAST) ? row_reg : row_reg + ROW_W'(1);
    assign wrap    = (CMP_W'(col_reg) >= cols_eff);
    assign row_eff = wrap ? row_inc : row_reg;
    assign col_eff = wrap ? '0 : col_reg;
    assign font_ok = (CMP_W'(s_font_offset) < GLYPH_BYTES);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && s_kind == KIND_PRINT) begin
            if (is_newline) begin
                col_next = '0;
                row_next = row_inc;
            end else begin
                col_next = col_eff + COL_W'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb begin
        push_valid = 1'b0;
        if (accept) begin
            push_valid = (s_kind == KIND_PRINT) ? !is_newline : font_ok;
        end
        push_entry.is_print   = (s_kind == KIND_PRINT);
        push_entry.bank       = s_font_offset[0];
        push_entry.font_byte  = s_font_byte;
        if (s_kind == KIND_PRINT) begin
            push_entry.row_addr = ROWADDR_W'(s_char_code) * ROWADDR_W'(MAX_GLYPH_HEIGHT);
        end else begin
            push_entry.row_addr = ROWADDR_W'(s_char_code) * ROWADDR_W'(MAX_GLYPH_HEIGHT)
                                + ROWADDR_W'(s_font_offset[OFFS_W-1:1]);
        end
        push_entry.last_row   = ROWIDX_W'(height_eff - CMP_W'(1));
        push_entry.pixel_x    = PX_W'(col_eff) * PX_W'(GLYPH_WIDTH);
        push_entry.pixel_y0   = PY_W'(row_eff) * PY_W'(height_eff);
        push_entry.off_screen = (CMP_W'(row_eff) >= rows_eff);
        push_entry.fg_color   = s_fg_color;
        push_entry.bg_color   = s_bg_color;
    end

endmodule

/* hw/rtl/bgtr_queue.sv */
// ----------------------------------------------------------------------------
// bgtr_queue
// Short register queue of work entries between front and back end.
// ----------------------------------------------------------------------------
module bgtr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    input  bgtr_pkg::bgtr_entry_t push_entry,
    output logic                  push_ready,
    output bgtr_pkg::bgtr_head_t  head,
    input  logic                  pop
);
    import bgtr_pkg::*;

    bgtr_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    always_comb begin
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hw/rtl/bgtr_back.sv */
// ----------------------------------------------------------------------------
// bgtr_back
// Executes work entries: stores font bytes in two byte banks and, for a glyph,
// reads one glyph row per cycle into a two-entry output buffer while it has room.
// ----------------------------------------------------------------------------
module bgtr_back #(
    parameter int MAX_GLYPH_HEIGHT = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bgtr_pkg::bgtr_head_t           head,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bgtr_pkg::PX_W-1:0]      m_pixel_x,
    output logic [bgtr_pkg::PY_W-1:0]      m_pixel_y,
    output logic [bgtr_pkg::BITS_W-1:0]    m_row_bits,
    output logic [bgtr_pkg::COLOR_W-1:0]   m_fg_color_out,
    output logic [bgtr_pkg::COLOR_W-1:0]   m_bg_color_out,
    output logic                           m_off_screen,
    output logic                           m_last
);
    import bgtr_pkg::*;

    localparam int MEM_DEPTH = 256 * MAX_GLYPH_HEIGHT;
    localparam int RA_W      = $clog2(MEM_DEPTH);

    typedef struct packed {
        logic [PX_W-1:0]    pixel_x;
        logic [PY_W-1:0]    pixel_y;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               off_screen;
        logic               last;
    } row_meta_t;

    typedef struct packed {
        row_meta_t          meta;
        logic [BITS_W-1:0]  bits;
    } out_item_t;

    logic [BYTE_W-1:0] even_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] odd_mem  [MEM_DEPTH];
    logic [BYTE_W-1:0] even_rd_reg, odd_rd_reg;

    logic [ROWIDX_W-1:0] row_reg, row_next;
    logic                rd_vld_reg;
    row_meta_t           rd_meta_reg, rd_meta_next;

    out_item_t   ob_reg [2];
    logic [1:0]  ob_cnt_reg, ob_cnt_next;
    logic        ob_head_reg;
    logic        ob_tail;
    logic [1:0]  occupancy;
    logic        out_take, can_issue, issue, font_wr, last_row;
    logic [RA_W-1:0] wr_addr, rd_addr;

    assign out_take  = m_valid && m_ready;
    assign occupancy = ob_cnt_reg + 2'(rd_vld_reg);
    // Issue a read only if its row is sure to find a buffer slot.
    assign can_issue = (occupancy < 2'd2) || (occupancy == 2'd2 && out_take);

    assign font_wr  = head.valid && !head.entry.is_print;
    assign issue    = head.valid && head.entry.is_print && can_issue;
    assign last_row = (row_reg == head.entry.last_row);
    assign pop      = font_wr || (issue && last_row);

    assign wr_addr = head.entry.row_addr[RA_W-1:0];
    assign rd_addr = RA_W'(head.entry.row_addr + ROWADDR_W'(row_reg));

    always_comb begin
        row_next = row_reg;
        if (issue) begin
            row_next = last_row ? '0 : row_reg + ROWIDX_W'(1);
        end
        rd_meta_next.pixel_x    = head.entry.pixel_x;
        rd_meta_next.pixel_y    = head.entry.pixel_y0 + PY_W'(row_reg);
        rd_meta_next.fg_color   = head.entry.fg_color;
        rd_meta_next.bg_color   = head.entry.bg_color;
        rd_meta_next.off_screen = head.entry.off_screen;
        rd_meta_next.last       = last_row;
    end

    always_ff @(posedge aclk) begin
        if (font_wr && !head.entry.bank) begin
            even_mem[wr_addr] <= head.entry.font_byte;
        end
        if (issue) begin
            even_rd_reg <= even_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (font_wr && head.entry.bank) begin
            odd_mem[wr_addr] <= head.entry.font_byte;
        end
        if (issue) begin
            odd_rd_reg <= odd_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_meta_reg <= rd_meta_next;
        end
    end

    assign ob_tail     = ob_head_reg ^ ob_cnt_reg[0];
    assign ob_cnt_next = ob_cnt_reg + 2'(rd_vld_reg) - 2'(out_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            ob_cnt_reg  <= '0;
            ob_head_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            rd_vld_reg  <= issue;
            ob_cnt_reg  <= ob_cnt_next;
            if (out_take) begin
                ob_head_reg <= !ob_head_reg;
            end
        end
    end

    // Land the read row in the buffer: byte0 then the top two bits of byte1.
    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            ob_reg[ob_tail].meta <= rd_meta_reg;
            ob_reg[ob_tail].bits <= {even_rd_reg, odd_rd_reg[BYTE_W-1 -: 2]};
        end
    end

    assign m_valid        = (ob_cnt_reg != '0);
    assign m_pixel_x      = ob_reg[ob_head_reg].meta.pixel_x;
    assign m_pixel_y      = ob_reg[ob_head_reg].meta.pixel_y;
    assign m_row_bits     = ob_reg[ob_head_reg].bits;
    assign m_fg_color_out = ob_reg[ob_head_reg].meta.fg_color;
    assign m_bg_color_out = ob_reg[ob_head_reg].meta.bg_color;
    assign m_off_screen   = ob_reg[ob_head_reg].meta.off_screen;
    assign m_last         = ob_reg[ob_head_reg].meta.last;

endmodule

/* hw/rtl/bitmap_glyph_text_renderer_core.sv */
// The first glyph row of a character passes through the queue, the font read registers and
// the output buffer before it is offered. Glyph rows follow at one per cycle while the output
// buffer has room, glyph_height rows (1..32) per character; newlines never reach the back end.
// A 4-entry queue lets the front keep accepting while the back end draws.
// Reset (aresetn low, synchronous): cursor to row 0 column 0, registers to 80/25/20, queue
// and output buffer empty; the font store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// bitmap_glyph_text_renderer_core
// Text console glyph renderer: font loading, cursor handling, glyph row output.
// ----------------------------------------------------------------------------
module bitmap_glyph_text_renderer_core #(
    parameter int MAX_COLS         = 256,
    parameter int MAX_ROWS         = 256,
    parameter int MAX_GLYPH_HEIGHT = 32,
    parameter int GLYPH_WIDTH      = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bgtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgtr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [bgtr_pkg::CODE_W-1:0]       s_char_code,
    input  logic [bgtr_pkg::OFFS_W-1:0]       s_font_offset,
    input  logic [bgtr_pkg::BYTE_W-1:0]       s_font_byte,
    input  logic [bgtr_pkg::COLOR_W-1:0]      s_fg_color,
    input  logic [bgtr_pkg::COLOR_W-1:0]      s_bg_color,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bgtr_pkg::PX_W-1:0]         m_pixel_x,
    output logic [bgtr_pkg::PY_W-1:0]         m_pixel_y,
    output logic [bgtr_pkg::BITS_W-1:0]       m_row_bits,
    output logic [bgtr_pkg::COLOR_W-1:0]      m_fg_color_out,
    output logic [bgtr_pkg::COLOR_W-1:0]      m_bg_color_out,
    output logic                              m_off_screen,
    output logic                              m_last
);
    import bgtr_pkg::*;

    logic        push_valid, push_ready, pop;
    bgtr_entry_t push_entry;
    bgtr_head_t  head;

    bgtr_front #(
        .MAX_COLS         (MAX_COLS),
        .MAX_ROWS         (MAX_ROWS),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .GLYPH_WIDTH      (GLYPH_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_char_code   (s_char_code),
        .s_font_offset (s_font_offset),
        .s_font_byte   (s_font_byte),
        .s_fg_color    (s_fg_color),
        .s_bg_color    (s_bg_color),
        .push_valid    (push_valid),
        .push_entry    (push_entry),
        .push_ready    (push_ready)
    );

    bgtr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    bgtr_back #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_row_bits     (m_row_bits),
        .m_fg_color_out (m_fg_color_out),
        .m_bg_color_out (m_bg_color_out),
        .m_off_screen   (m_off_screen),
        .m_last         (m_last)
    );

endmodule

/* hw/rtl/bgtr_checker.sv */
// ----------------------------------------------------------------------------
// bgtr_port_checker
// Port-level checks for the glyph renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_glyph_text_renderer_core_macros.svh"

module bgtr_port_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_we,
    input logic [bgtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [bgtr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_kind,
    input logic [bgtr_pkg::CODE_W-1:0]       s_char_code,
    input logic [bgtr_pkg::OFFS_W-1:0]       s_font_offset,
    input logic [bgtr_pkg::BYTE_W-1:0]       s_font_byte,
    input logic [bgtr_pkg::COLOR_W-1:0]      s_fg_color,
    input logic [bgtr_pkg::COLOR_W-1:0]      s_bg_color,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [bgtr_pkg::PX_W-1:0]         m_pixel_x,
    input logic [bgtr_pkg::PY_W-1:0]         m_pixel_y,
    input logic [bgtr_pkg::BITS_W-1:0]       m_row_bits,
    input logic [bgtr_pkg::COLOR_W-1:0]      m_fg_color_out,
    input logic [bgtr_pkg::COLOR_W-1:0]      m_bg_color_out,
    input logic                              m_off_screen,
    input logic                              m_last
);

    // A result waiting for the sink stays offered.
    `BGTR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // A stalled result keeps its pixel origin and bits.
    `BGTR_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_pixel_x) && $stable(m_pixel_y) && $stable(m_row_bits) && $stable(m_last))

    // Glyph columns are ten pixels wide, so the origin is always even.
    `BGTR_ASSERT_NOW(a_px_even, aclk, aresetn, m_valid, !m_pixel_x[0])

    // Reset leaves nothing to deliver and room for new items.
    `BGTR_ASSERT_AFTER_RESET(a_reset_empty, aclk, aresetn, !m_valid && s_ready)

endmodule

bind bitmap_glyph_text_renderer_core bgtr_port_checker u_bgtr_port_checker (.*);
